// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/trfe_pkg.sv =====
// ----------------------------------------------------------------------------
// trfe_pkg
// types and constants of the record field extractor
// ----------------------------------------------------------------------------
package trfe_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_UNSUPP    = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TOO_SMALL = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_FIELD_COUNT  = 3'd0,
        CFG_SPARSE_COUNT = 3'd1,
        CFG_TYPE_TABLE   = 3'd2,
        CFG_TARGET       = 3'd3,
        CFG_MAX_OUT      = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        TY_BYTE   = 4'd0,
        TY_SHORT  = 4'd1,
        TY_INT    = 4'd2,
        TY_LONG   = 4'd3,
        TY_STRING = 4'd4,
        TY_BINARY = 4'd5,
        TY_BOOL   = 4'd6,
        TY_FIXED  = 4'd7
    } t_type;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_valid;
        logic       done_res;
        logic [2:0] status;
    } t_out;

endpackage

// ===== rtl/trfe_if.sv =====
// ----------------------------------------------------------------------------
// trfe_if
// valid / ready channel carrying a payload
// ----------------------------------------------------------------------------
interface trfe_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/trfe_cfg_if.sv =====
// ----------------------------------------------------------------------------
// trfe_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface trfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/trfe_queue.sv =====
// ----------------------------------------------------------------------------
// trfe_queue
// short fifo between front and back part
// ----------------------------------------------------------------------------
module trfe_queue
    import trfe_pkg::*;
#(
    parameter int unsigned WIDTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/trfe_parser.sv =====
// ----------------------------------------------------------------------------
// trfe_parser
// back part: walks the record one byte a cycle while stepped and forms the result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module trfe_parser
    import trfe_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_field_count,
    input  logic [4:0]  i_sparse_count,
    input  logic [63:0] i_type_table,
    input  logic [3:0]  i_target_index,
    input  logic [31:0] i_max_output_len,
    input  logic        i_step,
    input  t_in         i_item,
    output t_out        o_res
);
    typedef enum logic [2:0] {
        PH_START, PH_COUNT, PH_INDEX, PH_FIXED, PH_LEN, PH_BODY
    } t_phase;

    // position and limit reach sparse offset plus a full count byte
    t_phase      r_phase, n_phase;
    logic [8:0]  r_pos, n_pos;
    logic [8:0]  r_limit, n_limit;
    logic [3:0]  r_type, n_type;
    logic [31:0] r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic        r_tgt, n_tgt;
    logic        r_fin, n_fin;

    logic [4:0] fc;
    logic       sp;
    logic [4:0] so;
    assign fc = (i_field_count > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : i_field_count;
    assign sp = (i_sparse_count <= fc);
    assign so = fc - (sp ? i_sparse_count : 5'd0);

    function automatic logic [3:0] type_of(input logic [3:0] n, input logic [63:0] tt);
        type_of = tt[{n, 2'b00} +: 4];
    endfunction

    // one field boundary at most per byte, so enter/begin are plain logic
    always_comb begin
        logic       done;
        logic [2:0] st;
        logic       ent;
        logic [8:0] ei;
        logic       bg;
        logic [3:0] bt;
        logic       btg;
        logic [3:0] w;
        logic [7:0] b;
        logic [32:0] need;
        n_phase = r_phase; n_pos = r_pos; n_limit = r_limit; n_type = r_type;
        n_left = r_left; n_acc = r_acc; n_tgt = r_tgt; n_fin = r_fin;
        done = 1'b0; st = ST_OK; ent = 1'b0; ei = 9'd0;
        bg = 1'b0; bt = 4'd0; btg = 1'b0; w = 4'd0;
        b = i_item.record_byte;
        need = 33'd0;
        o_res = '0;

        // start of record: enter field 0 first, then handle the byte
        if (!r_fin && r_phase == PH_START) begin
            n_limit = {4'd0, fc};
            if ({1'b0, i_target_index} >= fc) begin
                done = 1'b1; st = ST_NOT_FOUND; n_fin = 1'b1;
            end else begin
                n_pos = 9'd0;
                if (sp && so == 5'd0) n_phase = PH_COUNT;
                else begin
                    bg = 1'b1; bt = type_of(4'd0, i_type_table);
                    btg = (i_target_index == 4'd0);
                end
            end
        end
        if (bg) begin
            // start-of-record begin field
            n_type = bt; n_tgt = btg;
            unique case (bt)
                TY_BYTE, TY_BOOL: w = 4'd1;
                TY_SHORT: w = 4'd2;
                TY_INT: w = 4'd4;
                TY_LONG: w = 4'd8;
                TY_FIXED: w = 4'd10;
                default: w = 4'd0;
            endcase
            if (bt == TY_STRING || bt == TY_BINARY) begin
                n_phase = PH_LEN; n_left = 32'd4; n_acc = 32'd0;
            end else if (w == 4'd0) begin
                done = 1'b1; st = ST_UNSUPP; n_fin = 1'b1;
            end else if (btg && i_max_output_len < 32'(w)) begin
                done = 1'b1; st = ST_TOO_SMALL; n_fin = 1'b1;
            end else begin
                n_phase = PH_FIXED; n_left = 32'(w);
            end
        end
        bg = 1'b0;

        if (!n_fin) begin
            unique case (n_phase)
                PH_COUNT: begin
                    n_limit = n_pos + 9'(b);
                    n_phase = PH_INDEX;
                end
                PH_INDEX: begin
                    bg = 1'b1; bt = type_of(b[3:0], i_type_table);
                    btg = (b == {4'd0, i_target_index});
                end
                PH_FIXED, PH_BODY: begin
                    if (n_tgt) begin
                        o_res.value_byte = b; o_res.value_valid = 1'b1;
                    end
                    if (n_left != 32'd0) n_left = n_left - 32'd1;
                    if (n_left == 32'd0) begin
                        if (n_tgt) begin
                            done = 1'b1; st = ST_OK; n_fin = 1'b1;
                        end else begin
                            ent = 1'b1; ei = n_pos + 9'd1;
                        end
                    end
                end
                PH_LEN: begin
                    if (n_left >= 32'd1 && n_left <= 32'd4)
                        n_acc = n_acc | (32'(b) << {(2'd0 - n_left[1:0]), 3'b000});
                    if (n_left != 32'd0) n_left = n_left - 32'd1;
                    if (n_left == 32'd0) begin
                        need = {1'b0, n_acc} + 33'(n_type == TY_STRING);
                        if (n_type == TY_STRING && n_acc[31]) begin
                            done = 1'b1; st = ST_BAD_LEN; n_fin = 1'b1;
                        end else if (n_tgt && {1'b0, i_max_output_len} < need) begin
                            done = 1'b1; st = ST_TOO_SMALL; n_fin = 1'b1;
                        end else if (n_acc == 32'd0) begin
                            if (n_tgt) begin
                                done = 1'b1; st = ST_OK; n_fin = 1'b1;
                            end else begin
                                ent = 1'b1; ei = n_pos + 9'd1;
                            end
                        end else begin
                            n_phase = PH_BODY; n_left = n_acc;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (ent) begin
            n_pos = ei;
            if (ei >= n_limit) begin
                done = 1'b1; st = ST_NOT_FOUND; n_fin = 1'b1;
            end else if (sp && ei == {4'd0, so}) n_phase = PH_COUNT;
            else if (sp && ei > {4'd0, so}) n_phase = PH_INDEX;
            else begin
                bg = 1'b1; bt = type_of(ei[3:0], i_type_table);
                btg = (ei == {5'd0, i_target_index});
            end
        end
        if (bg) begin
            n_type = bt; n_tgt = btg;
            unique case (bt)
                TY_BYTE, TY_BOOL: w = 4'd1;
                TY_SHORT: w = 4'd2;
                TY_INT: w = 4'd4;
                TY_LONG: w = 4'd8;
                TY_FIXED: w = 4'd10;
                default: w = 4'd0;
            endcase
            if (bt == TY_STRING || bt == TY_BINARY) begin
                n_phase = PH_LEN; n_left = 32'd4; n_acc = 32'd0;
            end else if (w == 4'd0) begin
                done = 1'b1; st = ST_UNSUPP; n_fin = 1'b1;
            end else if (btg && i_max_output_len < 32'(w)) begin
                done = 1'b1; st = ST_TOO_SMALL; n_fin = 1'b1;
            end else begin
                n_phase = PH_FIXED; n_left = 32'(w);
            end
        end

        if (i_item.last_byte) begin
            if (!n_fin) begin
                done = 1'b1; st = ST_TRUNC;
            end
            n_phase = PH_START; n_pos = 9'd0; n_limit = 9'd0; n_type = 4'd0;
            n_left = 32'd0; n_acc = 32'd0; n_tgt = 1'b0; n_fin = 1'b0;
        end
        o_res.done_res = done;
        o_res.status = done ? st : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_pos <= '0; r_limit <= '0; r_type <= '0;
            r_left <= '0; r_acc <= '0; r_tgt <= 1'b0; r_fin <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_pos <= n_pos; r_limit <= n_limit; r_type <= n_type;
            r_left <= n_left; r_acc <= n_acc; r_tgt <= n_tgt; r_fin <= n_fin;
        end
    end

    `ASSERT_CLK(a_len_bound, i_clk, i_rst_n, (r_phase == PH_LEN) |-> (r_left <= 32'd4))
    `ASSERT_CLK(a_fin_restart, i_clk, i_rst_n, (i_step && i_item.last_byte) |=> !r_fin)
    `ASSERT_CLK(a_status_done, i_clk, i_rst_n, !o_res.done_res |-> (o_res.status == 3'd0))
endmodule

// ===== rtl/typed_record_field_extractor.sv =====
// ----------------------------------------------------------------------------
// typed_record_field_extractor
// walks a serialized record by schema and emits the target field value
// ----------------------------------------------------------------------------
// path: request accepted into the queue, then popped through the parser into the result reg
// throughput: one byte per cycle while the output is not stalled, set by the single-byte parser step
// reset: synchronous active low, clears parser state, queue and config regs
`include "assert_macros.svh"
module typed_record_field_extractor
    import trfe_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    trfe_cfg_if.sink     cfg,
    trfe_if.sink         in_ch,
    trfe_if.source       out_ch
);
    logic [4:0]  r_field_count, r_sparse_count;
    logic [63:0] r_type_table;
    logic [3:0]  r_target;
    logic [31:0] r_max_out;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= '0; r_sparse_count <= '0; r_type_table <= '0;
            r_target <= '0; r_max_out <= '0;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_FIELD_COUNT:  r_field_count <= cfg.data[4:0];
                CFG_SPARSE_COUNT: r_sparse_count <= cfg.data[4:0];
                CFG_TYPE_TABLE:   r_type_table <= cfg.data;
                CFG_TARGET:       r_target <= cfg.data[3:0];
                CFG_MAX_OUT:      r_max_out <= cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // front: accept requests into the queue
    logic q_full, q_empty, q_pop, push;
    t_in  q_data;
    t_out res;
    t_out r_out;
    logic r_ov;

    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;
    assign q_pop = !q_empty && (!r_ov || out_ch.ready);

    trfe_queue #(.WIDTH($bits(t_in))) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(in_ch.data[$bits(t_in)-1:0]), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_data)
    );

    trfe_parser #(.MAX_FIELDS(MAX_FIELDS)) u_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_field_count(r_field_count), .i_sparse_count(r_sparse_count),
        .i_type_table(r_type_table), .i_target_index(r_target),
        .i_max_output_len(r_max_out), .i_step(q_pop), .i_item(q_data), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (q_pop) r_out <= res;
        if (!i_rst_n) r_ov <= 1'b0;
        else if (q_pop) r_ov <= 1'b1;
        else if (out_ch.ready) r_ov <= 1'b0;
    end
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_out;

    `ASSERT_CLK(a_no_overrun, i_clk, i_rst_n, (r_ov && !out_ch.ready) |-> !q_pop)
    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, q_pop |-> !q_empty)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (r_ov && !out_ch.ready) |=> $stable(r_out))
endmodule

// ===== bench/trfe_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfe_tb_pkg
// constants shared by the bench
// ----------------------------------------------------------------------------
package trfe_tb_pkg;
    // quiet cycles after a drain before the schema changes
    localparam int unsigned IDLE_CYCLES_END = 8;
endpackage

// ===== bench/typed_record_field_extractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_record_field_extractor_tb
// feeds serialized records under several schemas, predicts every per-byte
// result in a behavioural model of the parser and compares field by field
// ----------------------------------------------------------------------------
module typed_record_field_extractor_tb;
    import trfe_pkg::*;
    import trfe_tb_pkg::*;

    localparam int PH_START = 0, PH_COUNT = 1, PH_INDEX = 2, PH_FIXED = 3,
        PH_LEN = 4, PH_BODY = 5;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    trfe_cfg_if cfg ();
    trfe_if #(.WIDTH($bits(t_in))) in_ch ();
    trfe_if #(.WIDTH($bits(t_out))) out_ch ();

    typed_record_field_extractor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
    );

    always #2 i_clk = ~i_clk;

    // schema copy
    logic [4:0]  m_fcount, m_scount;
    logic [63:0] m_types;
    logic [3:0]  m_target;
    logic [31:0] m_maxlen;
    // parser copy
    int unsigned p_phase, p_pos, p_limit, p_type, p_left, p_len;
    bit p_tgt, p_fin;
    t_out pr;

    t_in  byte_q[$];
    t_out result_q[$];
    int   src_idle = 17, snk_idle = 53;
    bit   hold = 0;
    bit   in_taken = 0;
    int   errors = 0;
    int   quiet = 0;

    function automatic int unsigned eff_count();
        return (m_fcount > 16) ? 16 : m_fcount;
    endfunction

    function automatic int unsigned type_at(int unsigned n);
        return (m_types >> (4 * (n & 15))) & 15;
    endfunction

    function automatic void settle(t_status st);
        p_fin = 1;
        pr.done_res = 1;
        pr.status = st;
    endfunction

    function automatic void open_field(int unsigned t, bit tgt);
        int unsigned w;
        p_type = t;
        p_tgt = tgt;
        case (t)
            TY_BYTE, TY_BOOL: w = 1;
            TY_SHORT: w = 2;
            TY_INT: w = 4;
            TY_LONG: w = 8;
            TY_FIXED: w = 10;
            TY_STRING, TY_BINARY: begin
                p_phase = PH_LEN;
                p_left = 4;
                p_len = 0;
                return;
            end
            default: begin
                settle(ST_UNSUPP);
                return;
            end
        endcase
        if (tgt && m_maxlen < w) begin
            settle(ST_TOO_SMALL);
            return;
        end
        p_phase = PH_FIXED;
        p_left = w;
    endfunction

    function automatic void go_field(int unsigned i);
        int unsigned fc, so;
        bit sp;
        fc = eff_count();
        sp = m_scount <= fc;
        so = fc - (sp ? m_scount : 0);
        p_pos = i;
        if (i >= p_limit) settle(ST_NOT_FOUND);
        else if (sp && i == so) p_phase = PH_COUNT;
        else if (sp && i > so) p_phase = PH_INDEX;
        else open_field(type_at(i), i == m_target);
    endfunction

    function automatic void close_field();
        if (p_tgt) settle(ST_OK);
        else go_field(p_pos + 1);
    endfunction

    function automatic void length_known();
        longint unsigned need;
        if (p_type == TY_STRING && p_len[31]) begin
            settle(ST_BAD_LEN);
            return;
        end
        if (p_tgt) begin
            need = longint'(p_len) + (p_type == TY_STRING ? 1 : 0);
            if (longint'(m_maxlen) < need) begin
                settle(ST_TOO_SMALL);
                return;
            end
        end
        if (p_len == 0) begin
            close_field();
            return;
        end
        p_phase = PH_BODY;
        p_left = p_len;
    endfunction

    function automatic void parser_clear();
        p_phase = PH_START; p_pos = 0; p_limit = 0; p_type = 0;
        p_left = 0; p_len = 0; p_tgt = 0; p_fin = 0;
    endfunction

    function automatic t_out parse_byte(t_in it);
        int unsigned b;
        b = it.record_byte;
        pr = '0;
        if (!p_fin && p_phase == PH_START) begin
            p_limit = eff_count();
            if (m_target >= p_limit) settle(ST_NOT_FOUND);
            else go_field(0);
        end
        if (!p_fin) begin
            case (p_phase)
                PH_COUNT: begin
                    p_limit = p_pos + b;
                    p_phase = PH_INDEX;
                end
                PH_INDEX: open_field(type_at(b), b == m_target);
                PH_FIXED, PH_BODY: begin
                    if (p_tgt) begin
                        pr.value_byte = b;
                        pr.value_valid = 1;
                    end
                    if (p_left > 0) p_left--;
                    if (p_left == 0) close_field();
                end
                PH_LEN: begin
                    if (p_left >= 1 && p_left <= 4) p_len |= b << (8 * (4 - p_left));
                    if (p_left > 0) p_left--;
                    if (p_left == 0) length_known();
                end
                default: ;
            endcase
        end
        if (it.last_byte) begin
            if (!p_fin) settle(ST_TRUNC);
            parser_clear();
        end
        return pr;
    endfunction

    // driver: moves on only after the request was taken at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
            in_ch.data <= '0;
        end else if (!in_ch.valid || in_taken) begin
            if (byte_q.size() > 0 && !hold && $urandom_range(99) >= src_idle) begin
                in_ch.data <= byte_q.pop_front();
                in_ch.valid <= 1;
            end else begin
                in_ch.valid <= 0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_idle);
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (in_ch.valid && in_ch.ready) begin
                result_q.push_back(parse_byte(t_in'(in_ch.data)));
            end
            if (out_ch.valid && out_ch.ready) begin
                t_out got, want;
                got = t_out'(out_ch.data);
                if (result_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.value_byte !== want.value_byte) begin
                        $error("value_byte exp %h got %h", want.value_byte, got.value_byte);
                        errors++;
                    end
                    if (got.value_valid !== want.value_valid) begin
                        $error("value_valid exp %b got %b", want.value_valid,
                            got.value_valid);
                        errors++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res exp %b got %b", want.done_res, got.done_res);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("typed_record_field_extractor_tb failed");
                $finish;
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] v);
        @(negedge i_clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            CFG_FIELD_COUNT: m_fcount = v[4:0];
            CFG_SPARSE_COUNT: m_scount = v[4:0];
            CFG_TYPE_TABLE: m_types = v;
            CFG_TARGET: m_target = v[3:0];
            default: m_maxlen = v[31:0];
        endcase
        @(negedge i_clk);
        cfg.valid <= 0;
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || result_q.size() > 0 || in_ch.valid) @(posedge i_clk);
        repeat (IDLE_CYCLES_END) @(posedge i_clk);
    endtask

    task automatic push_byte(int unsigned b, bit l);
        t_in it;
        it.record_byte = b;
        it.last_byte = l;
        byte_q.push_back(it);
    endtask

    // well-formed record under the current schema, with random corruption
    task automatic make_record();
        int unsigned fc, so, n, t, len, k;
        bit sp;
        fc = eff_count();
        sp = m_scount <= fc;
        so = fc - (sp ? m_scount : 0);
        for (int i = 0; i < fc; i++) begin
            if (sp && i == so) begin
                n = fc - so;
                push_byte(($urandom_range(9) == 0) ? $urandom_range(255) : n, 0);
                for (int j = so; j < fc; j++) begin
                    k = ($urandom_range(11) == 0) ? $urandom_range(255) : j;
                    push_byte(k, 0);
                    t = type_at(k);
                    if (t == TY_STRING || t == TY_BINARY) begin
                        len = $urandom_range(6);
                        if ($urandom_range(30) == 0) len = 32'h8000_0000 | $urandom();
                        for (int q = 0; q < 4; q++) push_byte((len >> (8 * q)) & 255, 0);
                        for (int q = 0; q < len && q < 6; q++) push_byte($urandom_range(255), 0);
                    end else begin
                        repeat (t == 3 ? 8 : t == 7 ? 10 : t == 2 ? 4 : t == 1 ? 2 : 1)
                            push_byte($urandom_range(255), 0);
                    end
                end
                break;
            end
            t = type_at(i);
            if (t == TY_STRING || t == TY_BINARY) begin
                len = $urandom_range(6);
                for (int q = 0; q < 4; q++) push_byte((len >> (8 * q)) & 255, 0);
                repeat (len) push_byte($urandom_range(255), 0);
            end else begin
                repeat (t == 3 ? 8 : t == 7 ? 10 : t == 2 ? 4 : t == 1 ? 2 : 1)
                    push_byte($urandom_range(255), 0);
            end
        end
        // trailing bytes, sometimes cut short
        if ($urandom_range(4) == 0 && byte_q.size() > 0) void'(byte_q.pop_back());
        repeat ($urandom_range(2)) push_byte($urandom_range(255), 0);
        push_byte($urandom_range(255), 1);
    endtask

    task automatic random_schema();
        logic [63:0] tt;
        tt = '0;
        for (int i = 0; i < 16; i++)
            tt[4 * i +: 4] = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(7);
        cfg_write(CFG_FIELD_COUNT, $urandom_range(1, 6));
        cfg_write(CFG_SPARSE_COUNT, ($urandom_range(5) == 0) ? $urandom_range(31) :
            $urandom_range(0, 3));
        cfg_write(CFG_TYPE_TABLE, tt);
        cfg_write(CFG_TARGET, $urandom_range(0, 6));
        cfg_write(CFG_MAX_OUT, ($urandom_range(3) == 0) ? $urandom_range(8) :
            (($urandom_range(5) == 0) ? 32'hffff_ffff : 64));
    endtask

    initial begin
        int fed;
        cfg.valid = 0;
        cfg.index = CFG_FIELD_COUNT;
        cfg.data = '0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        m_fcount = 0; m_scount = 0; m_types = 0; m_target = 0; m_maxlen = 0;
        parser_clear();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // empty schema, then extremes of the fields
        push_byte(8'h00, 0);
        push_byte(8'hff, 1);
        push_byte(8'h5a, 1);
        drain();
        cfg_write(CFG_FIELD_COUNT, 31);
        cfg_write(CFG_SPARSE_COUNT, 2);
        cfg_write(CFG_TYPE_TABLE, 64'hf876_5432_1076_5432);
        cfg_write(CFG_TARGET, 15);
        cfg_write(CFG_MAX_OUT, 32'hffff_ffff);
        push_byte(8'h11, 0);
        push_byte(8'h22, 0); push_byte(8'h33, 0); push_byte(8'h44, 0); push_byte(8'h55, 0);
        push_byte(8'hee, 1);
        drain();
        cfg_write(CFG_FIELD_COUNT, 3);
        cfg_write(CFG_SPARSE_COUNT, 0);
        cfg_write(CFG_TYPE_TABLE, 64'h0000_0000_0000_0454);
        cfg_write(CFG_TARGET, 1);
        cfg_write(CFG_MAX_OUT, 0);
        // negative string length, zero-length string then zero-length binary target with no capacity
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h80, 0);
        push_byte(8'h00, 1);
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);
        drain();

        fed = 0;
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 17 : (ph == 1) ? 53 : 0;
            snk_idle = (ph == 0) ? 53 : (ph == 1) ? 17 : 0;
            while (fed < 667 * (ph + 1)) begin
                random_schema();
                repeat ($urandom_range(2, 6)) make_record();
                fed += byte_q.size();
                if ($urandom_range(3) == 0) begin
                    // sender waits for every outstanding result
                    hold = 1;
                    while (result_q.size() > 0 || in_ch.valid) @(posedge i_clk);
                    hold = 0;
                end
                drain();
            end
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("typed_record_field_extractor_tb passed");
        end else begin
            $display("typed_record_field_extractor_tb failed");
        end
        $finish;
    end
endmodule
